[src/damd_pkg.sv]
// Shared types, constants and record-length decode for the delta affine matrix decoder.
package damd_pkg;

  // Default number of matrices in one block
  localparam int unsigned BlockMatricesDef = 16;
  localparam int unsigned NumAcc           = 6;
  localparam int unsigned RecDepth         = 7;

  typedef logic [15:0]               word_t;
  typedef logic [NumAcc-1:0][15:0]   acc_vec_t;
  typedef logic [RecDepth-1:0][15:0] rec_vec_t;

  // Accumulator slots
  localparam logic [2:0] AccA  = 3'd0;
  localparam logic [2:0] AccB  = 3'd1;
  localparam logic [2:0] AccC  = 3'd2;
  localparam logic [2:0] AccD  = 3'd3;
  localparam logic [2:0] AccTx = 3'd4;
  localparam logic [2:0] AccTy = 3'd5;

  // Record modes (low nibble of the flags word)
  localparam logic [3:0] ModeXy14   = 4'd1;
  localparam logic [3:0] ModeAdxy7  = 4'd2;
  localparam logic [3:0] ModeAdxy11 = 4'd3;
  localparam logic [3:0] ModeAll7   = 4'd5;
  localparam logic [3:0] ModeAll10  = 4'd6;
  localparam logic [3:0] ModeAll12  = 4'd7;
  localparam logic [3:0] ModeFull   = 4'd15;

  // Record length in words, counting the flags word; zero for an unknown mode
  function automatic logic [2:0] record_len(input word_t flags);
    logic [2:0] len;
    len = 3'd0;
    if (flags[1:0] == 2'b00) begin
      len = 3'd1;
    end else begin
      case (flags[3:0])
        ModeXy14, ModeAdxy7:  len = 3'd2;
        ModeAdxy11, ModeAll7: len = 3'd3;
        ModeAll10:            len = 3'd4;
        ModeAll12:            len = 3'd5;
        ModeFull:             len = 3'd7;
        default:              len = 3'd0;
      endcase
    end
    return len;
  endfunction

endpackage

[src/damd_ifs.sv]
// Valid/ready channel interfaces for the decoder's word input and matrix output.
interface damd_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] word;

  modport source (output valid, output kind, output word, input ready);
  modport sink   (input valid, input kind, input word, output ready);
endinterface

interface damd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_a;
  logic signed [15:0] out_b;
  logic signed [15:0] out_c;
  logic signed [15:0] out_d;
  logic signed [15:0] out_tx;
  logic signed [15:0] out_ty;
  logic        [3:0]  position_in_block;
  logic               bad_encoding;

  modport source (output valid, output out_a, output out_b, output out_c, output out_d,
                  output out_tx, output out_ty, output position_in_block,
                  output bad_encoding, input ready);
  modport sink   (input valid, input out_a, input out_b, input out_c, input out_d,
                  input out_tx, input out_ty, input position_in_block,
                  input bad_encoding, output ready);
endinterface

[src/delta_affine_matrix_decoder.sv]
// Delta affine matrix decoder: top level with accumulators, record store and result register.
//
// Accepts one 16-bit word per clock cycle and decodes it in the cycle it is
// accepted: base words (kind 0) load a, b, c, d, tx, ty in turn; delta words
// (kind 1) build records of 1 to 7 words, and the word that completes a record
// updates the accumulators and places the matrix in the result register, valid
// from the next cycle on. The input stays ready while the result register is
// empty or its matrix is being taken, so a full stream runs at one word per
// cycle; only a stalled output holds the input. An unknown record mode gives
// one result with bad_encoding set and drops delta words until the next base
// word.
module delta_affine_matrix_decoder import damd_pkg::*; #(
  parameter int unsigned BLOCK_MATRICES = BlockMatricesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  damd_in_if.sink     in_i,
  damd_out_if.source  out_o
);

  acc_vec_t   acc_q, acc_d;
  word_t      rec_q [RecDepth];
  logic [2:0] wc_q, wc_d;
  logic [2:0] base_q, base_d;
  logic [3:0] pos_q, pos_d;
  logic       disc_q, disc_d;

  logic       out_valid_q;
  acc_vec_t   res_acc_q, res_acc_d;
  logic [3:0] res_pos_q;
  logic       res_bad_q, res_bad_d;

  logic       in_rdy;
  logic       fire;
  logic       emit;
  rec_vec_t   w_cur;
  acc_vec_t   delta;
  acc_vec_t   acc_sum;
  logic [2:0] len;
  logic [4:0] pos_inc;

  assign in_rdy   = ~out_valid_q | out_o.ready;
  assign in_i.ready = in_rdy;
  assign fire     = in_i.valid & in_rdy;

  // Record view with the incoming word in its slot
  always_comb begin
    for (int i = 0; i < RecDepth; i++) begin
      w_cur[i] = (3'(i) == wc_q) ? in_i.word : rec_q[i];
    end
  end

  assign len = record_len(w_cur[0]);

  damd_delta_calc u_delta (
    .w_i     (w_cur),
    .delta_o (delta)
  );

  always_comb begin
    for (int i = 0; i < NumAcc; i++) begin
      acc_sum[i] = acc_q[i] + delta[i];
    end
  end

  assign pos_inc = {1'b0, pos_q} + 5'd1;

  // Decode state update
  always_comb begin
    acc_d     = acc_q;
    wc_d      = wc_q;
    base_d    = base_q;
    pos_d     = pos_q;
    disc_d    = disc_q;
    emit      = 1'b0;
    res_acc_d = acc_sum;
    res_bad_d = 1'b0;
    if (fire) begin
      if (!in_i.kind) begin
        // base word load
        acc_d[base_q] = in_i.word;
        wc_d          = '0;
        disc_d        = 1'b0;
        if (base_q == 3'(NumAcc - 1)) begin
          base_d = '0;
          pos_d  = '0;
        end else begin
          base_d = base_q + 3'd1;
        end
      end else if (!disc_q) begin
        if (len == 3'd0) begin
          // unknown mode on the flags word
          emit      = 1'b1;
          res_bad_d = 1'b1;
          res_acc_d = '0;
          wc_d      = '0;
          disc_d    = 1'b1;
        end else if (wc_q + 3'd1 == len) begin
          emit  = 1'b1;
          acc_d = acc_sum;
          wc_d  = '0;
          pos_d = (pos_inc >= 5'(BLOCK_MATRICES)) ? 4'd0 : pos_inc[3:0];
        end else begin
          wc_d = wc_q + 3'd1;
        end
      end
    end
  end

  // Control and accumulator registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      wc_q        <= '0;
      base_q      <= '0;
      pos_q       <= '0;
      disc_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      wc_q   <= wc_d;
      base_q <= base_d;
      pos_q  <= pos_d;
      disc_q <= disc_d;
      if (in_rdy) begin
        out_valid_q <= emit;
      end
    end
  end

  // Record word store
  always_ff @(posedge clk_i) begin
    if (fire && in_i.kind && !disc_q) begin
      rec_q[wc_q] <= in_i.word;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_acc_q <= res_acc_d;
      res_pos_q <= pos_q;
      res_bad_q <= res_bad_d;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.out_a             = res_acc_q[AccA];
  assign out_o.out_b             = res_acc_q[AccB];
  assign out_o.out_c             = res_acc_q[AccC];
  assign out_o.out_d             = res_acc_q[AccD];
  assign out_o.out_tx            = res_acc_q[AccTx];
  assign out_o.out_ty            = res_acc_q[AccTy];
  assign out_o.position_in_block = res_pos_q;
  assign out_o.bad_encoding      = res_bad_q;

`ifndef SYNTH
  // While discarding no record is in progress
  a_disc_no_record: assert property (@(posedge clk_i) disc_q |-> wc_q == 3'd0)
    else $error("record count nonzero while discarding");

  // A base word ends discarding and drops a partial record
  a_base_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !in_i.kind) |=> (!disc_q && wc_q == 3'd0))
    else $error("base word did not clear record state");

  // An error result carries an all-zero matrix
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_bad_q) |-> (res_acc_q == '0))
    else $error("error result with nonzero matrix");

  // An error result puts the decoder into discard
  a_bad_discards: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && res_bad_d) |=> disc_q)
    else $error("unknown mode did not start discarding");

  // Base load index stays within the six accumulators
  a_base_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_q <= 3'(NumAcc - 1))
    else $error("base load index out of range");
`endif

endmodule

[src/damd_delta_calc.sv]
// Unpacks the signed deltas of one complete record into six 16-bit addends.
module damd_delta_calc import damd_pkg::*; (
  input  rec_vec_t w_i,
  output acc_vec_t delta_o
);

  logic [47:0] p;
  logic [47:0] t6;
  logic [47:0] t7;
  word_t       flags;

  assign flags = w_i[0];
  assign p     = {w_i[2], w_i[1], w_i[0]};
  assign t6    = {w_i[3], w_i[2], w_i[1]};
  assign t7    = {w_i[4], w_i[3], w_i[2]};

  // Field extraction per mode, sign extended to 16 bits
  always_comb begin
    delta_o = '0;
    if (flags[1:0] == 2'b00) begin
      // one-word record: small translation step
      delta_o[AccTx] = 16'($signed(flags[8:2]));
      delta_o[AccTy] = 16'($signed(flags[15:9]));
    end else begin
      case (flags[3:0])
        ModeXy14: begin
          delta_o[AccTx] = 16'($signed(p[17:4]));
          delta_o[AccTy] = 16'($signed(p[31:18]));
        end
        ModeAdxy7: begin
          delta_o[AccA]  = 16'($signed(p[10:4]));
          delta_o[AccD]  = 16'($signed(p[17:11]));
          delta_o[AccTx] = 16'($signed(p[24:18]));
          delta_o[AccTy] = 16'($signed(p[31:25]));
        end
        ModeAdxy11: begin
          delta_o[AccA]  = 16'($signed(p[14:4]));
          delta_o[AccD]  = 16'($signed(p[25:15]));
          delta_o[AccTx] = 16'($signed(p[36:26]));
          delta_o[AccTy] = 16'($signed(p[47:37]));
        end
        ModeAll7: begin
          delta_o[AccA]  = 16'($signed(p[10:4]));
          delta_o[AccB]  = 16'($signed(p[17:11]));
          delta_o[AccC]  = 16'($signed(p[24:18]));
          delta_o[AccD]  = 16'($signed(p[31:25]));
          delta_o[AccTx] = 16'($signed(p[39:32]));
          delta_o[AccTy] = 16'($signed(p[47:40]));
        end
        ModeAll10: begin
          delta_o[AccA]  = 16'($signed(p[13:4]));
          delta_o[AccB]  = 16'($signed(p[23:14]));
          delta_o[AccC]  = 16'($signed(p[33:24]));
          delta_o[AccD]  = 16'($signed(p[43:34]));
          delta_o[AccTx] = 16'($signed(t6[37:28]));
          delta_o[AccTy] = 16'($signed(t6[47:38]));
        end
        ModeAll12: begin
          delta_o[AccA]  = 16'($signed(p[15:4]));
          delta_o[AccB]  = 16'($signed(p[27:16]));
          delta_o[AccC]  = 16'($signed(p[39:28]));
          delta_o[AccD]  = 16'($signed(t7[19:8]));
          delta_o[AccTx] = 16'($signed(t7[33:20]));
          delta_o[AccTy] = 16'($signed(t7[47:34]));
        end
        ModeFull: begin
          // whole-word deltas
          delta_o[AccA]  = w_i[1];
          delta_o[AccB]  = w_i[2];
          delta_o[AccC]  = w_i[3];
          delta_o[AccD]  = w_i[4];
          delta_o[AccTx] = w_i[5];
          delta_o[AccTy] = w_i[6];
        end
        default: delta_o = '0;
      endcase
    end
  end

endmodule
